### design/wls_pkg.sv
// Shared constants, register codes and multiplier interface types for the leapfrog stencil block.
package wls_pkg;

	localparam int PRESSURE_BITS = 48;
	localparam int MAX_POINTS    = 1024;
	localparam int IDX_W         = $clog2(MAX_POINTS);
	localparam int SPEED_W       = 32;
	localparam int DT_W          = 32;
	localparam int AMP_W         = 47;
	localparam int ORDER_W       = 2;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 47;

	localparam int LIMB_W = 32;
	localparam int OPND_W = 2 * LIMB_W;
	localparam int ACC_W  = 4 * LIMB_W;

	localparam int NUM_W        = PRESSURE_BITS + 7;
	localparam int BASE_W       = PRESSURE_BITS + 4;
	localparam int LMAG_W       = PRESSURE_BITS + 4;
	localparam int TERM_W       = 64;
	localparam int SUM_W        = TERM_W + 1;
	localparam int DIV_SHIFT    = 54;
	localparam int K_SHIFT      = 48;
	localparam int KF_W         = 48;
	localparam int TERM_SHIFT   = 30;
	localparam int TERM_CAP_BIT = 62;
	localparam int TERM_SAT_BIT = TERM_SHIFT + TERM_CAP_BIT;

	localparam logic [OPND_W-1:0] RECIP3 =
		((OPND_W'(1) << DIV_SHIFT) + OPND_W'(2)) / OPND_W'(3);
	localparam logic [ACC_W-1:0] K_ROUND = ACC_W'(1) << (K_SHIFT - 1);
	localparam logic [ACC_W-1:0] T_ROUND = ACC_W'(1) << (TERM_SHIFT - 1);
	localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << TERM_CAP_BIT;

	localparam logic [ORDER_W-1:0]     ORDER_THREE_POINT = ORDER_W'(1);
	localparam logic [1:0]             HALF_THREE        = 2'd1;
	localparam logic [1:0]             HALF_FIVE         = 2'd2;

	localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(2);
	localparam logic [DT_W-1:0]    DT_RST    = DT_W'(10737418);
	localparam logic [AMP_W-1:0]   AMP_RST   = AMP_W'(10995116);
	localparam logic [IDX_W-1:0]   SRC_RST   = IDX_W'(500);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ORDER = 2'd0,
		REG_DT    = 2'd1,
		REG_AMP   = 2'd2,
		REG_SRC   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [OPND_W-1:0] a;
		logic [OPND_W-1:0] b;
		logic [ACC_W-1:0]  init;
	} mac_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] acc;
	} mac_rsp_t;

endpackage

### design/wls_mac.sv
// Shared 32 by 32 multiplier that builds a 64 by 64 product limb by limb into an accumulator.
module wls_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  wls_pkg::mac_req_t req,
	output wls_pkg::mac_rsp_t rsp
);
	import wls_pkg::*;

	logic [OPND_W-1:0]   a_q;
	logic [OPND_W-1:0]   b_q;
	logic [1:0]          step_q;
	logic                issue_q;
	logic [OPND_W-1:0]   prod_s1;
	logic [1:0]          pos_s1;
	logic                valid_s1;
	logic                last_s1;
	logic                done_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    addend;
	logic [LIMB_W-1:0]   a_limb;
	logic [LIMB_W-1:0]   b_limb;

	assign a_limb = step_q[0] ? a_q[OPND_W-1:LIMB_W] : a_q[LIMB_W-1:0];
	assign b_limb = step_q[1] ? b_q[OPND_W-1:LIMB_W] : b_q[LIMB_W-1:0];

	always_comb begin
		unique case (pos_s1)
			2'd0:    addend = {{(ACC_W - OPND_W){1'b0}}, prod_s1};
			2'd1:    addend = {{(ACC_W - OPND_W - LIMB_W){1'b0}}, prod_s1, {LIMB_W{1'b0}}};
			default: addend = {prod_s1, {(ACC_W - OPND_W){1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			step_q   <= 2'd0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= issue_q;
			last_s1  <= issue_q && (step_q == 2'd3);
			done_q   <= valid_s1 && last_s1;
			if (req.start) begin
				issue_q <= 1'b1;
				step_q  <= 2'd0;
			end else if (issue_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		prod_s1 <= a_limb * b_limb;
		pos_s1  <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
		if (req.start) begin
			acc_q <= req.init;
		end else if (valid_s1) begin
			acc_q <= acc_q + addend;
		end
	end

	assign rsp.done = done_q;
	assign rsp.acc  = acc_q;

endmodule

### design/wave_leapfrog_stencil_step_top.sv
// Top level of the streaming leapfrog wave equation stencil update for one grid row.
//
// Grid points of a row enter in order on the input channel (in_valid, in_ready); each item
// carries the current and previous pressure and the wave speed of one point. Results leave on
// the output channel (out_valid, out_ready), lagging the inputs by the stencil half-width, and
// the point flagged as last flushes the remaining results of the row, the final one marked.
// Every result is computed by one shared 32 by 32 multiplier: a product of up to 64 by 64 bits
// takes four limb passes. With the five-point stencil a result takes the products divide by
// twelve, speed squared, scaling and Laplacian term in that order, and with the three-point one
// the same without the division; an item that releases no result leaves the block ready for
// the next one; a last point adds its flush steps. The block takes no item while it computes.
// Configuration is written through cfg_we, cfg_index and cfg_data while the block is idle.
// Reset clears the stencil window, the point counter and the output valid flag, and loads the
// configuration defaults. A result waits in the output register while the receiver stalls;
// the block takes the next item meanwhile, but holds a further result until that one is taken.
module wave_leapfrog_stencil_step_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [wls_pkg::CFG_INDEX_W-1:0]          cfg_index,
	input  logic [wls_pkg::CFG_DATA_W-1:0]           cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [wls_pkg::PRESSURE_BITS-1:0] p_now,
	input  logic signed [wls_pkg::PRESSURE_BITS-1:0] p_prev,
	input  logic [wls_pkg::SPEED_W-1:0]              speed,
	input  logic                                     first_step,
	input  logic                                     last_point,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [wls_pkg::PRESSURE_BITS-1:0] p_next,
	output logic [wls_pkg::IDX_W-1:0]                point_index,
	output logic                                     row_done
);
	import wls_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FLUSH = 7'b0000010,
		S_LAP   = 7'b0000100,
		S_SUM   = 7'b0001000,
		S_ABS   = 7'b0010000,
		S_MUL   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		PH_DIV  = 4'b0001,
		PH_SQ   = 4'b0010,
		PH_K    = 4'b0100,
		PH_TERM = 4'b1000
	} phase_t;

	localparam logic signed [SUM_W-1:0] P_MAX =
		{{(SUM_W - PRESSURE_BITS + 1){1'b0}}, {(PRESSURE_BITS - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] P_MIN = ~P_MAX;

	state_t state_q;
	phase_t phase_q;

	logic [ORDER_W-1:0] order_q;
	logic [DT_W-1:0]    dt_q;
	logic [AMP_W-1:0]   amp_q;
	logic [IDX_W-1:0]   src_q;

	logic signed [PRESSURE_BITS-1:0] win_q [5];
	logic signed [PRESSURE_BITS-1:0] prev_q [3];
	logic [SPEED_W-1:0]              spd_q [3];

	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] idx_q;
	logic             flag_q;
	logic             last_q;
	logic             flushing_q;
	logic             done_bit_q;
	logic [1:0]       fill_q;
	logic [1:0]       k_q;

	logic signed [NUM_W-1:0]  pa_q;
	logic signed [NUM_W-1:0]  pb_q;
	logic signed [NUM_W-1:0]  pc_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [BASE_W-1:0] base_q;
	logic [LMAG_W-1:0]        lmag_q;
	logic                     neg_q;
	logic signed [TERM_W-1:0] term_q;

	logic                            out_valid_q;
	logic signed [PRESSURE_BITS-1:0] p_next_q;
	logic [IDX_W-1:0]                point_index_q;
	logic                            row_done_q;

	logic                            five;
	logic [1:0]                      half;
	logic [1:0]                      hk;
	logic                            accept;
	logic                            flush_emit;
	logic                            k_last;
	logic                            out_load;
	logic                            clear_row;
	logic                            push_zero;
	logic                            src_hit;
	logic signed [PRESSURE_BITS-1:0] wc;
	logic signed [PRESSURE_BITS-1:0] pv;
	logic [SPEED_W-1:0]              cv;
	logic signed [NUM_W-1:0]         e0, e1, e2, e3, e4;
	logic signed [NUM_W-1:0]         pa_d, pb_d, pc_d;
	logic signed [BASE_W-1:0]        amp_add;
	logic signed [BASE_W-1:0]        base_d;
	logic                            neg;
	logic [NUM_W-1:0]                ones;
	logic [2:0]                      rnd_add;
	logic [NUM_W-1:0]                rnd;
	logic [TERM_W-1:0]               tmag;
	logic signed [TERM_W-1:0]        term_d;
	logic signed [SUM_W-1:0]         sum;
	logic signed [SUM_W-1:0]         sat;
	mac_req_t                        mac_req;
	mac_rsp_t                        mac_rsp;

	wls_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	assign five       = (order_q != ORDER_THREE_POINT);
	assign half       = five ? HALF_FIVE : HALF_THREE;
	assign hk         = half - k_q;
	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign flush_emit = (hk < fill_q);
	assign k_last     = (k_q == half);
	assign push_zero  = (state_q == S_FLUSH);
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign clear_row  = (push_zero && !flush_emit && k_last) ||
		(out_load && flushing_q && k_last);
	assign src_hit    = flag_q && (idx_q == src_q);

	assign wc = five ? win_q[2] : win_q[3];
	assign pv = five ? prev_q[2] : prev_q[1];
	assign cv = five ? spd_q[2] : spd_q[1];

	assign e0 = NUM_W'(win_q[0]);
	assign e1 = NUM_W'(win_q[1]);
	assign e2 = NUM_W'(win_q[2]);
	assign e3 = NUM_W'(win_q[3]);
	assign e4 = NUM_W'(win_q[4]);

	assign pa_d = five ? ((e1 + e3) <<< 4) : (e4 + e2);
	assign pb_d = five ? ((e2 <<< 5) - (e2 <<< 1)) : (e3 <<< 1);
	assign pc_d = five ? (e0 + e4) : '0;

	assign amp_add = src_hit ? signed'(BASE_W'(amp_q)) : '0;
	assign base_d  = (BASE_W'(wc) <<< 1) - BASE_W'(pv) + amp_add;

	// Magnitude and round-half-away offset share one adder: for a negative value the
	// ones' complement plus one more than the offset gives the negated sum.
	assign neg     = num_q[NUM_W-1];
	assign ones    = neg ? ~num_q : num_q;
	assign rnd_add = five ? (neg ? 3'd7 : 3'd6) : {2'b00, neg};
	assign rnd     = ones + NUM_W'(rnd_add);

	assign tmag   = (|mac_rsp.acc[ACC_W-1:TERM_SAT_BIT]) ? TERM_CAP :
		TERM_W'(mac_rsp.acc[TERM_SAT_BIT-1:TERM_SHIFT]);
	assign term_d = neg_q ? -signed'(tmag) : signed'(tmag);

	assign sum = SUM_W'(base_q) + SUM_W'(term_q);

	always_comb begin
		priority if (sum > P_MAX) begin
			sat = P_MAX;
		end else if (sum < P_MIN) begin
			sat = P_MIN;
		end else begin
			sat = sum;
		end
	end

	always_comb begin
		mac_req = '0;
		priority if (state_q == S_ABS) begin
			mac_req.start = 1'b1;
			if (five) begin
				mac_req.a = OPND_W'(rnd[NUM_W-1:2]);
				mac_req.b = RECIP3;
			end else begin
				mac_req.a = OPND_W'(cv);
				mac_req.b = OPND_W'(cv);
			end
		end else if ((state_q == S_MUL) && mac_rsp.done) begin
			unique case (phase_q)
				PH_DIV: begin
					mac_req.start = 1'b1;
					mac_req.a     = OPND_W'(cv);
					mac_req.b     = OPND_W'(cv);
				end
				PH_SQ: begin
					mac_req.start = 1'b1;
					mac_req.a     = mac_rsp.acc[OPND_W-1:0];
					mac_req.b     = OPND_W'(dt_q);
					mac_req.init  = K_ROUND;
				end
				PH_K: begin
					mac_req.start = 1'b1;
					mac_req.a     = OPND_W'(mac_rsp.acc[K_SHIFT +: KF_W]);
					mac_req.b     = OPND_W'(lmag_q);
					mac_req.init  = T_ROUND;
				end
				default: begin
					mac_req.start = 1'b0;
				end
			endcase
		end else begin
			mac_req.start = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RST;
			dt_q    <= DT_RST;
			amp_q   <= AMP_RST;
			src_q   <= SRC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORDER: order_q <= cfg_data[ORDER_W-1:0];
				REG_DT:    dt_q    <= cfg_data[DT_W-1:0];
				REG_AMP:   amp_q   <= cfg_data[AMP_W-1:0];
				REG_SRC:   src_q   <= cfg_data[IDX_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				spd_q[i]  <= '0;
			end
		end else if (clear_row) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				spd_q[i]  <= '0;
			end
		end else if (accept || push_zero) begin
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[4]  <= accept ? p_now : '0;
			prev_q[2] <= prev_q[1];
			prev_q[1] <= prev_q[0];
			prev_q[0] <= accept ? p_prev : '0;
			spd_q[2]  <= spd_q[1];
			spd_q[1]  <= spd_q[0];
			spd_q[0]  <= accept ? speed : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_DIV;
			fill_q      <= 2'd0;
			k_q         <= 2'd0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
			last_q      <= 1'b0;
			flushing_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (clear_row) begin
				fill_q <= 2'd0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						flag_q     <= first_step;
						last_q     <= last_point;
						flushing_q <= 1'b0;
						cnt_q      <= last_point ? '0 : cnt_q + IDX_W'(1);
						if (fill_q >= half) begin
							state_q <= S_LAP;
						end else begin
							fill_q <= fill_q + 2'd1;
							if (last_point) begin
								flushing_q <= 1'b1;
								k_q        <= 2'd1;
								state_q    <= S_FLUSH;
							end
						end
					end
				end
				S_FLUSH: begin
					if (flush_emit) begin
						state_q <= S_LAP;
					end else if (k_last) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_LAP: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_ABS;
				end
				S_ABS: begin
					state_q <= S_MUL;
					phase_q <= five ? PH_DIV : PH_SQ;
				end
				S_MUL: begin
					if (mac_rsp.done) begin
						unique case (phase_q)
							PH_DIV:  phase_q <= PH_SQ;
							PH_SQ:   phase_q <= PH_K;
							PH_K:    phase_q <= PH_TERM;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_OUT: begin
					if (out_load) begin
						if (flushing_q) begin
							if (k_last) begin
								state_q <= S_IDLE;
							end else begin
								k_q     <= k_q + 2'd1;
								state_q <= S_FLUSH;
							end
						end else if (last_q) begin
							flushing_q <= 1'b1;
							k_q        <= 2'd1;
							state_q    <= S_FLUSH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q        <= cnt_q;
			idx_q      <= cnt_q - IDX_W'(half);
			done_bit_q <= 1'b0;
		end
		if (push_zero && flush_emit) begin
			idx_q      <= n_q - IDX_W'(hk);
			done_bit_q <= k_last;
		end
		if (state_q == S_LAP) begin
			pa_q   <= pa_d;
			pb_q   <= pb_d;
			pc_q   <= pc_d;
			base_q <= base_d;
		end
		if (state_q == S_SUM) begin
			num_q <= pa_q - pb_q - pc_q;
		end
		if (state_q == S_ABS) begin
			neg_q <= neg;
			if (!five) begin
				lmag_q <= LMAG_W'(rnd);
			end
		end
		if ((state_q == S_MUL) && mac_rsp.done) begin
			if (phase_q == PH_DIV) begin
				lmag_q <= mac_rsp.acc[DIV_SHIFT +: LMAG_W];
			end
			if (phase_q == PH_TERM) begin
				term_q <= term_d;
			end
		end
		if (out_load) begin
			p_next_q      <= PRESSURE_BITS'(sat);
			point_index_q <= idx_q;
			row_done_q    <= done_bit_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign p_next      = p_next_q;
	assign point_index = point_index_q;
	assign row_done    = row_done_q;

endmodule

### bench/tb_wave_leapfrog_stencil_step_top.sv
// Self-checking bench for the leapfrog stencil block: streamed grid rows, handshake stalls, checks.
module tb_wave_leapfrog_stencil_step_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wls_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS  = 440;

	localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
	localparam longint OUT_MAX = (longint'(1) << (PRESSURE_BITS - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;

	localparam logic signed [PRESSURE_BITS-1:0] P_MAX = {1'b0, {(PRESSURE_BITS-1){1'b1}}};
	localparam logic signed [PRESSURE_BITS-1:0] P_MIN = {1'b1, {(PRESSURE_BITS-1){1'b0}}};
	localparam logic signed [PRESSURE_BITS-1:0] P_ONE = PRESSURE_BITS'(1) << 40;
	localparam logic [SPEED_W-1:0]              SPEED_ONE = SPEED_W'(1) << 24;
	localparam logic [ORDER_W-1:0]              ORDER_FIVE_ZERO  = 2'd0;
	localparam logic [ORDER_W-1:0]              ORDER_FIVE_THREE = 2'd3;

	typedef struct packed {
		logic signed [PRESSURE_BITS-1:0] p_now;
		logic signed [PRESSURE_BITS-1:0] p_prev;
		logic [SPEED_W-1:0]              speed;
		logic                            first_step;
		logic                            last_point;
	} grid_point_t;

	typedef struct packed {
		logic signed [PRESSURE_BITS-1:0] p_next;
		logic [IDX_W-1:0]                idx;
		logic                            done;
	} row_result_t;

	logic                            clk        = 1'b0;
	logic                            arst_n     = 1'b0;
	logic                            cfg_we     = 1'b0;
	logic [CFG_INDEX_W-1:0]          cfg_index  = '0;
	logic [CFG_DATA_W-1:0]           cfg_data   = '0;
	logic                            in_valid   = 1'b0;
	logic                            in_ready;
	logic signed [PRESSURE_BITS-1:0] p_now      = '0;
	logic signed [PRESSURE_BITS-1:0] p_prev     = '0;
	logic [SPEED_W-1:0]              speed      = '0;
	logic                            first_step = 1'b0;
	logic                            last_point = 1'b0;
	logic                            out_valid;
	logic                            out_ready  = 1'b0;
	logic signed [PRESSURE_BITS-1:0] p_next;
	logic [IDX_W-1:0]                point_index;
	logic                            row_done;

	wave_leapfrog_stencil_step_top i_dut (.*);

	logic [ORDER_W-1:0]              cfg_order = ORDER_RST;
	logic [DT_W-1:0]                 cfg_dt    = DT_RST;
	logic [AMP_W-1:0]                cfg_amp   = AMP_RST;
	logic [IDX_W-1:0]                cfg_src   = SRC_RST;
	logic signed [PRESSURE_BITS-1:0] win [5];
	logic signed [PRESSURE_BITS-1:0] prv [3];
	logic [SPEED_W-1:0]              spd [3];
	logic [IDX_W-1:0]                row_pos;
	logic                            src_flag = 1'b0;
	int                              fill;

	grid_point_t grid_point_q [$];
	row_result_t next_pressure_q [$];
	grid_point_t drive_pt;
	row_result_t want;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int items_taken    = 0;
	int results_seen   = 0;
	int rows_sent      = 0;
	int err_cnt        = 0;
	int random_budget  = 0;
	int phase          = 0;

	function automatic longint sum_sat(longint a, longint b);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic longint diff_sat(longint a, longint b);
		longint s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63])
			return a[63] ? S64_MIN : S64_MAX;
		return s;
	endfunction

	function automatic longint dbl_sat(longint a, int n);
		for (int i = 0; i < n; i++)
			a = sum_sat(a, a);
		return a;
	endfunction

	function automatic logic [63:0] abs_mag(longint v);
		return v[63] ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic row_result_t step_result(logic [1:0] h, logic [IDX_W-1:0] idx,
			logic done);
		longint      w [5];
		longint      n16, n30, num, term, nxt;
		logic [63:0] lmag, mag, s2, kf, tmag;
		logic [127:0] prod;
		row_result_t r;
		for (int i = 0; i < 5; i++)
			w[i] = longint'(win[i]);
		if (h == HALF_THREE) begin
			num  = diff_sat(sum_sat(w[4], w[2]), dbl_sat(w[3], 1));
			lmag = abs_mag(num);
		end else begin
			n16  = dbl_sat(sum_sat(w[1], w[3]), 4);
			n30  = diff_sat(dbl_sat(w[2], 5), dbl_sat(w[2], 1));
			num  = diff_sat(diff_sat(n16, n30), sum_sat(w[0], w[4]));
			mag  = abs_mag(num);
			lmag = (mag < 64'd6) ? 64'd0 : (mag - 64'd6) / 64'd12 + 64'd1;
		end
		s2   = 64'(spd[h]) * 64'(spd[h]);
		prod = 128'(s2) * 128'(cfg_dt) + (128'd1 << 47);
		kf   = prod[111:48];
		prod = 128'(kf) * 128'(lmag) + (128'd1 << 29);
		tmag = (prod[127:64] >= (64'd1 << 28)) ? (64'd1 << 62) : prod[93:30];
		term = num[63] ? -longint'(tmag) : longint'(tmag);
		nxt  = sum_sat(w[4 - h], w[4 - h]);
		nxt  = diff_sat(nxt, longint'(prv[h]));
		nxt  = sum_sat(nxt, term);
		if (src_flag && idx == cfg_src)
			nxt = sum_sat(nxt, longint'(cfg_amp));
		if (nxt > OUT_MAX)
			nxt = OUT_MAX;
		if (nxt < OUT_MIN)
			nxt = OUT_MIN;
		r.p_next = nxt[PRESSURE_BITS-1:0];
		r.idx    = idx;
		r.done   = done;
		return r;
	endfunction

	task automatic shift_in(logic signed [PRESSURE_BITS-1:0] p, logic signed [PRESSURE_BITS-1:0] q,
			logic [SPEED_W-1:0] c);
		for (int i = 0; i < 4; i++)
			win[i] = win[i + 1];
		win[4] = p;
		for (int i = 2; i > 0; i--) begin
			prv[i] = prv[i - 1];
			spd[i] = spd[i - 1];
		end
		prv[0] = q;
		spd[0] = c;
	endtask

	task automatic clear_window();
		for (int i = 0; i < 5; i++)
			win[i] = '0;
		for (int i = 0; i < 3; i++) begin
			prv[i] = '0;
			spd[i] = '0;
		end
		fill    = 0;
		row_pos = '0;
	endtask

	task automatic leapfrog_update(grid_point_t pt);
		logic [1:0]       h;
		logic [IDX_W-1:0] n;
		h        = (cfg_order == ORDER_THREE_POINT) ? HALF_THREE : HALF_FIVE;
		n        = row_pos;
		src_flag = pt.first_step;
		shift_in(pt.p_now, pt.p_prev, pt.speed);
		if (fill >= h)
			next_pressure_q.push_back(step_result(h, n - IDX_W'(h), 1'b0));
		else
			fill++;
		if (pt.last_point) begin
			for (int k = 1; k <= h; k++) begin
				shift_in('0, '0, '0);
				if (h - k < fill)
					next_pressure_q.push_back(step_result(h, n - IDX_W'(h - k), k == h));
			end
			clear_window();
		end else begin
			row_pos = n + 1'b1;
		end
	endtask

	function automatic logic signed [PRESSURE_BITS-1:0] pick_pressure(bit gentle);
		logic [63:0] r;
		longint      s;
		r = {$urandom, $urandom};
		s = longint'(r[31:0]) << $urandom_range(0, 15);
		if (r[32])
			s = -s;
		if (gentle)
			return s[PRESSURE_BITS-1:0];
		case ($urandom_range(0, 7))
			0: return P_MAX;
			1: return P_MIN;
			2: return '0;
			3, 4, 5: return s[PRESSURE_BITS-1:0];
			default: return r[PRESSURE_BITS-1:0];
		endcase
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return SPEED_ONE + SPEED_W'($urandom_range(0, 1 << 22));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [AMP_W-1:0] pick_amp();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[AMP_W-1:0] >> $urandom_range(0, 40);
	endfunction

	function automatic int row_len();
		case ($urandom_range(0, 9))
			0: return 1;
			1: return 2;
			2: return 3;
			9: return $urandom_range(13, 40);
			default: return $urandom_range(4, 12);
		endcase
	endfunction

	task automatic queue_point(logic signed [PRESSURE_BITS-1:0] p,
			logic signed [PRESSURE_BITS-1:0] q, logic [SPEED_W-1:0] c, logic fs, logic lp);
		grid_point_t pt;
		pt.p_now      = p;
		pt.p_prev     = q;
		pt.speed      = c;
		pt.first_step = fs;
		pt.last_point = lp;
		grid_point_q.push_back(pt);
		if (lp)
			rows_sent++;
	endtask

	task automatic add_row(int len, bit fs, bit close, bit gentle);
		for (int i = 0; i < len; i++)
			queue_point(pick_pressure(gentle), pick_pressure(gentle), pick_speed(),
				($urandom_range(0, 9) == 0) ? !fs : fs, close && (i == len - 1));
	endtask

	task automatic apply_settings(logic [ORDER_W-1:0] order, logic [DT_W-1:0] dt,
			logic [AMP_W-1:0] amp, logic [IDX_W-1:0] src);
		cfg_order = order;
		cfg_dt    = dt;
		cfg_amp   = amp;
		cfg_src   = src;
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ORDER;
		cfg_data  <= CFG_DATA_W'(order);
		@(posedge clk);
		cfg_index <= REG_DT;
		cfg_data  <= CFG_DATA_W'(dt);
		@(posedge clk);
		cfg_index <= REG_AMP;
		cfg_data  <= CFG_DATA_W'(amp);
		@(posedge clk);
		cfg_index <= REG_SRC;
		cfg_data  <= CFG_DATA_W'(src);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// The settling wait follows the last checked result, before the next settings are written.
	task automatic wait_drained();
		while (grid_point_q.size() != 0 || in_valid || next_pressure_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				leapfrog_update(drive_pt);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (grid_point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_pt    = grid_point_q.pop_front();
					in_valid   <= 1'b1;
					p_now      <= drive_pt.p_now;
					p_prev     <= drive_pt.p_prev;
					speed      <= drive_pt.speed;
					first_step <= drive_pt.first_step;
					last_point <= drive_pt.last_point;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (next_pressure_q.size() == 0) begin
					$display("%0t: unexpected item p_next %0d index %0d row_done %0b",
						$time, p_next, point_index, row_done);
					err_cnt++;
				end else begin
					want = next_pressure_q.pop_front();
					if (p_next !== want.p_next || point_index !== want.idx ||
							row_done !== want.done) begin
						$display("%0t: expected p_next %0d index %0d row_done %0b, got %0d %0d %0b",
							$time, $signed(want.p_next), want.idx, want.done,
							p_next, point_index, row_done);
						err_cnt++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int  rows;
		bit  close;
		clear_window();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, five-point stencil: two rows shorter than the stencil, one full row, full-scale swings.
		queue_point(P_MAX, P_MIN, '1, 1'b0, 1'b1);
		queue_point(P_MIN, P_MAX, '1, 1'b1, 1'b0);
		queue_point(P_MAX, P_MAX, '0, 1'b1, 1'b1);
		queue_point('0, '0, SPEED_ONE, 1'b0, 1'b0);
		queue_point(P_MAX, P_MIN, '1, 1'b0, 1'b0);
		queue_point(P_MIN, P_MAX, '1, 1'b0, 1'b0);
		queue_point(P_MAX, P_MIN, '1, 1'b0, 1'b0);
		queue_point(P_ONE, -P_ONE, SPEED_ONE, 1'b0, 1'b1);
		wait_drained();

		// Three-point stencil with the largest scale factor and source at the second point.
		apply_settings(ORDER_THREE_POINT, '1, '1, IDX_W'(1));
		queue_point(P_ONE, '0, SPEED_ONE, 1'b1, 1'b1);
		queue_point(P_MAX, P_MIN, '1, 1'b1, 1'b0);
		queue_point(P_MIN, P_MAX, '1, 1'b1, 1'b0);
		queue_point(P_MAX, P_MIN, '1, 1'b1, 1'b0);
		queue_point(P_MIN, P_MAX, '1, 1'b0, 1'b1);
		queue_point(P_ONE, -P_ONE, '0, 1'b1, 1'b0);
		queue_point(-P_ONE, P_ONE, '0, 1'b1, 1'b0);
		queue_point(P_ONE, '0, '0, 1'b1, 1'b1);

		while (random_budget < RANDOM_ITEMS) begin
			wait_drained();
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			case (phase % 5)
				0: apply_settings(ORDER_THREE_POINT, '1, '1, '0);
				1: apply_settings(ORDER_RST, '0, '0, '1);
				2: apply_settings(ORDER_FIVE_ZERO, $urandom, pick_amp(),
					IDX_W'($urandom_range(0, 6)));
				3: apply_settings(ORDER_FIVE_THREE, DT_RST, AMP_RST,
					IDX_W'($urandom_range(0, 6)));
				default: apply_settings(ORDER_THREE_POINT, $urandom, pick_amp(),
					IDX_W'($urandom_range(0, 10)));
			endcase
			rows = $urandom_range(3, 6);
			for (int r = 0; r < rows; r++) begin
				int len;
				len   = row_len();
				close = (r < rows - 1) || ($urandom_range(0, 4) != 0);
				add_row(len, $urandom_range(0, 1), close, 1'b0);
				random_budget += len;
			end
			phase++;
		end
		add_row($urandom_range(1, 5), 1'b1, 1'b1, 1'b0);
		wait_drained();

		$display("Streamed %0d grid points in %0d complete rows across %0d setting phases.",
			items_taken, rows_sent, phase + 2);
		$display("Checked %0d next-pressure items, %0d of them wrong or unexpected.",
			results_seen, err_cnt);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
